// ----- rtl/bsp_pkg.sv -----
// shared types, constants and a helper for the 24-bit bmp stream parser
package bsp_pkg;

   localparam int DIMENSION_BITS_DEFAULT = 17;
   localparam int OUT_DIM_BITS = 17;

   localparam logic [16:0] MAX_DIMENSION_RESET = 17'd100000;

   localparam logic [7:0]  MAGIC_FIRST  = 8'h42;
   localparam logic [7:0]  MAGIC_SECOND = 8'h4D;
   localparam logic [15:0] DEPTH_24     = 16'd24;

   // byte offsets inside the 54-byte header
   localparam logic [5:0] POS_MAGIC_FIRST  = 6'd0;
   localparam logic [5:0] POS_MAGIC_SECOND = 6'd1;
   localparam logic [5:0] POS_WIDTH_LO     = 6'd18;
   localparam logic [5:0] POS_WIDTH_HI     = 6'd21;
   localparam logic [5:0] POS_HEIGHT_LO    = 6'd22;
   localparam logic [5:0] POS_HEIGHT_HI    = 6'd25;
   localparam logic [5:0] POS_DEPTH_LO     = 6'd28;
   localparam logic [5:0] POS_DEPTH_HI     = 6'd29;
   localparam logic [5:0] POS_HEADER_LAST  = 6'd53;

   typedef enum logic [2:0] {
      KIND_HEADER_OK = 3'd0,
      KIND_PIXEL     = 3'd1,
      KIND_PAD       = 3'd2,
      KIND_FORMAT    = 3'd3,
      KIND_PREMATURE = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PIXELS  = 2'd1,
      PH_DONE    = 2'd2,
      PH_STOPPED = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
      logic       restart;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [16:0] image_width;
      logic [16:0] image_height;
      logic [16:0] column;
      logic [16:0] row;
      logic        image_done;
   } rsp_type;

   // signed 32-bit dimension must lie in 1..limit
   function automatic logic dim_ok(input logic [31:0] word, input logic [31:0] limit);
      logic ok;
      begin
         ok = !word[31] && (word != 32'd0) && (word <= limit);
         return ok;
      end
   endfunction

endpackage

// ----- rtl/bmp24_stream_parser_top.sv -----
// Decoder for uncompressed 24-bit bmp files fed one byte per request. It takes one request
// every cycle while the result register is free or being drained; each request yields at most
// one result, through the input register, single-pass header and pixel decode, and result
// register. The 54-byte header yields a header-ok or format-error result on its last byte,
// or a format error on the second byte when the magic is wrong or on an end of stream within
// it; an end of stream among the pixels yields a premature result. Pixel bytes come out as one
// rgb result per blue, green, red triple, then a pad result for each row padding byte; the
// final result of the image carries image_done. Set restart on a request to begin a new file
// with its byte. max_dimension may only be written while no request is in flight.
module bmp24_stream_parser_top #(
   parameter int DIMENSION_BITS = bsp_pkg::DIMENSION_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bsp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsp_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [16:0]      csr_wr_data
);

   logic [16:0]      max_dimension_ff, max_dimension_in;
   logic             out_free, stage_valid, stage_take, res_valid;
   bsp_pkg::req_type stage_data;
   bsp_pkg::rsp_type res_data;

   assign max_dimension_in = csr_wr_en ? csr_wr_data : max_dimension_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dimension_ff <= bsp_pkg::MAX_DIMENSION_RESET;
      end else begin
         max_dimension_ff <= max_dimension_in;
      end
   end

   bsp_req_stage u_req_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .out_free    (out_free),
      .stage_valid (stage_valid),
      .stage_take  (stage_take),
      .stage_data  (stage_data)
   );

   bsp_parser #(
      .DIMENSION_BITS (DIMENSION_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (stage_take),
      .item          (stage_data),
      .max_dimension (max_dimension_ff),
      .res_valid     (res_valid),
      .res_data      (res_data)
   );

   bsp_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (stage_take && res_valid),
      .load_data (res_data),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a stalled result must not be overwritten by the decode stage
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !stage_take)
      else $error("decode advanced while a result was stalled");

   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      stage_take |-> stage_valid)
      else $error("decode advanced without a request");

   a_accept_path: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> stage_valid)
      else $error("accepted request did not reach the decode stage");

endmodule

// ----- rtl/bsp_req_stage.sv -----
// input register holding one request for the decode stage
module bsp_req_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bsp_pkg::req_type req_data,
   input  logic             out_free,
   output logic             stage_valid,
   output logic             stage_take,
   output bsp_pkg::req_type stage_data
);

   logic             valid_ff, valid_in;
   bsp_pkg::req_type data_ff, data_in;

   assign stage_take  = valid_ff && out_free;
   assign req_ready   = !valid_ff || out_free;
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

// ----- rtl/bsp_parser.sv -----
// header check, pixel regrouping and row padding tracking for one byte per cycle while step is high
module bsp_parser #(
   parameter int DIMENSION_BITS = bsp_pkg::DIMENSION_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  bsp_pkg::req_type item,
   input  logic [16:0]      max_dimension,
   output logic             res_valid,
   output bsp_pkg::rsp_type res_data
);

   localparam logic [31:0] DIM_CAP = 32'((64'd1 << DIMENSION_BITS) - 64'd1);

   bsp_pkg::phase_type phase_ff, phase_in;
   logic [5:0]  pos_ff, pos_in;
   logic        magic_ok_ff, magic_ok_in;
   logic [31:0] width_word_ff, width_word_in;
   logic [31:0] height_word_ff, height_word_in;
   logic [15:0] depth_word_ff, depth_word_in;
   logic [1:0]  pbi_ff, pbi_in;
   logic [7:0]  held_blue_ff, held_blue_in;
   logic [7:0]  held_green_ff, held_green_in;
   logic [DIMENSION_BITS-1:0] col_ff, col_in;
   logic [DIMENSION_BITS-1:0] row_ff, row_in;
   logic [1:0]  pad_ff, pad_in;
   logic [DIMENSION_BITS-1:0] img_w_ff, img_w_in;
   logic [DIMENSION_BITS-1:0] img_h_ff, img_h_in;

   // state as seen by this byte, after an optional restart
   bsp_pkg::phase_type cur_phase;
   logic [5:0]  cur_pos;
   logic        cur_magic_ok;
   logic [31:0] cur_width_word, cur_height_word;
   logic [15:0] cur_depth_word;
   logic [1:0]  cur_pbi;
   logic [7:0]  cur_blue, cur_green;
   logic [DIMENSION_BITS-1:0] cur_col, cur_row, cur_img_w, cur_img_h;
   logic [1:0]  cur_pad;

   logic [31:0] limit32;
   logic [5:0]  width_ofs, height_ofs, depth_ofs;
   logic        magic_fail, header_last, header_good;
   logic        in_pixel, pixel_emit, row_end, last_row;
   logic [DIMENSION_BITS-1:0] col_inc;
   logic [DIMENSION_BITS:0]   row_inc;
   logic [1:0]  pad_inc;
   logic [31:0] out_w32, out_h32, out_col32, out_row32;

   always_comb begin
      if (item.restart) begin
         cur_phase       = bsp_pkg::PH_HEADER;
         cur_pos         = '0;
         cur_magic_ok    = 1'b0;
         cur_width_word  = '0;
         cur_height_word = '0;
         cur_depth_word  = '0;
         cur_pbi         = '0;
         cur_blue        = '0;
         cur_green       = '0;
         cur_col         = '0;
         cur_row         = '0;
         cur_pad         = '0;
         cur_img_w       = '0;
         cur_img_h       = '0;
      end else begin
         cur_phase       = phase_ff;
         cur_pos         = pos_ff;
         cur_magic_ok    = magic_ok_ff;
         cur_width_word  = width_word_ff;
         cur_height_word = height_word_ff;
         cur_depth_word  = depth_word_ff;
         cur_pbi         = pbi_ff;
         cur_blue        = held_blue_ff;
         cur_green       = held_green_ff;
         cur_col         = col_ff;
         cur_row         = row_ff;
         cur_pad         = pad_ff;
         cur_img_w       = img_w_ff;
         cur_img_h       = img_h_ff;
      end
   end

   // shared decode conditions
   always_comb begin
      limit32 = (32'(max_dimension) < DIM_CAP) ? 32'(max_dimension) : DIM_CAP;
      width_ofs   = cur_pos - bsp_pkg::POS_WIDTH_LO;
      height_ofs  = cur_pos - bsp_pkg::POS_HEIGHT_LO;
      depth_ofs   = cur_pos - bsp_pkg::POS_DEPTH_LO;
      magic_fail  = (cur_pos == bsp_pkg::POS_MAGIC_SECOND) &&
                    (!cur_magic_ok || item.data_byte != bsp_pkg::MAGIC_SECOND);
      header_last = (cur_pos == bsp_pkg::POS_HEADER_LAST);
      header_good = bsp_pkg::dim_ok(cur_width_word, limit32) &&
                    bsp_pkg::dim_ok(cur_height_word, limit32) &&
                    (cur_depth_word == bsp_pkg::DEPTH_24);
      in_pixel    = (cur_col < cur_img_w);
      pixel_emit  = in_pixel && (cur_pbi == 2'd2);
      col_inc     = cur_col + 1'b1;
      pad_inc     = cur_pad + 2'd1;
      row_inc     = {1'b0, cur_row} + 1'b1;
      last_row    = (row_inc >= {1'b0, cur_img_h});
      if (in_pixel) begin
         row_end = pixel_emit && (col_inc == cur_img_w) && (cur_img_w[1:0] == 2'd0);
      end else begin
         row_end = (pad_inc == cur_img_w[1:0]);
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         phase_in = cur_phase;
         case (cur_phase)
            bsp_pkg::PH_HEADER: begin
               if (item.end_of_stream || magic_fail) begin
                  phase_in = bsp_pkg::PH_STOPPED;
               end else if (header_last) begin
                  phase_in = header_good ? bsp_pkg::PH_PIXELS : bsp_pkg::PH_STOPPED;
               end
            end
            bsp_pkg::PH_PIXELS: begin
               if (item.end_of_stream) begin
                  phase_in = bsp_pkg::PH_STOPPED;
               end else if (row_end && last_row) begin
                  phase_in = bsp_pkg::PH_DONE;
               end
            end
            default: phase_in = cur_phase;
         endcase
      end
   end

   // datapath updates and result
   always_comb begin
      pos_in         = pos_ff;
      magic_ok_in    = magic_ok_ff;
      width_word_in  = width_word_ff;
      height_word_in = height_word_ff;
      depth_word_in  = depth_word_ff;
      pbi_in         = pbi_ff;
      held_blue_in   = held_blue_ff;
      held_green_in  = held_green_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      pad_in         = pad_ff;
      img_w_in       = img_w_ff;
      img_h_in       = img_h_ff;
      res_valid      = 1'b0;
      res_data       = '0;
      res_data.kind  = bsp_pkg::KIND_FORMAT;
      out_w32        = 32'(cur_img_w);
      out_h32        = 32'(cur_img_h);
      out_col32      = '0;
      out_row32      = '0;
      if (step) begin
         pos_in         = cur_pos;
         magic_ok_in    = cur_magic_ok;
         width_word_in  = cur_width_word;
         height_word_in = cur_height_word;
         depth_word_in  = cur_depth_word;
         pbi_in         = cur_pbi;
         held_blue_in   = cur_blue;
         held_green_in  = cur_green;
         col_in         = cur_col;
         row_in         = cur_row;
         pad_in         = cur_pad;
         img_w_in       = cur_img_w;
         img_h_in       = cur_img_h;
         case (cur_phase)
            bsp_pkg::PH_HEADER: begin
               if (item.end_of_stream || magic_fail) begin
                  res_valid     = 1'b1;
                  res_data.kind = bsp_pkg::KIND_FORMAT;
               end else begin
                  if (cur_pos == bsp_pkg::POS_MAGIC_FIRST) begin
                     magic_ok_in = (item.data_byte == bsp_pkg::MAGIC_FIRST);
                  end
                  if (cur_pos >= bsp_pkg::POS_WIDTH_LO && cur_pos <= bsp_pkg::POS_WIDTH_HI) begin
                     width_word_in[8*width_ofs[1:0] +: 8] = item.data_byte;
                  end
                  if (cur_pos >= bsp_pkg::POS_HEIGHT_LO &&
                      cur_pos <= bsp_pkg::POS_HEIGHT_HI) begin
                     height_word_in[8*height_ofs[1:0] +: 8] = item.data_byte;
                  end
                  if (cur_pos >= bsp_pkg::POS_DEPTH_LO && cur_pos <= bsp_pkg::POS_DEPTH_HI) begin
                     depth_word_in[8*depth_ofs[0] +: 8] = item.data_byte;
                  end
                  if (header_last) begin
                     res_valid = 1'b1;
                     if (header_good) begin
                        res_data.kind = bsp_pkg::KIND_HEADER_OK;
                        img_w_in      = cur_width_word[DIMENSION_BITS-1:0];
                        img_h_in      = cur_height_word[DIMENSION_BITS-1:0];
                        out_w32       = 32'(cur_width_word[DIMENSION_BITS-1:0]);
                        out_h32       = 32'(cur_height_word[DIMENSION_BITS-1:0]);
                     end else begin
                        res_data.kind = bsp_pkg::KIND_FORMAT;
                     end
                  end else begin
                     pos_in = cur_pos + 6'd1;
                  end
               end
            end
            bsp_pkg::PH_PIXELS: begin
               if (item.end_of_stream) begin
                  res_valid     = 1'b1;
                  res_data.kind = bsp_pkg::KIND_PREMATURE;
                  out_col32     = 32'(cur_col);
                  out_row32     = 32'(cur_row);
               end else if (in_pixel && cur_pbi == 2'd0) begin
                  held_blue_in = item.data_byte;
                  pbi_in       = 2'd1;
               end else if (in_pixel && cur_pbi == 2'd1) begin
                  held_green_in = item.data_byte;
                  pbi_in        = 2'd2;
               end else begin
                  res_valid = 1'b1;
                  out_row32 = 32'(cur_row);
                  if (in_pixel) begin
                     res_data.kind  = bsp_pkg::KIND_PIXEL;
                     res_data.red   = item.data_byte;
                     res_data.green = cur_green;
                     res_data.blue  = cur_blue;
                     out_col32      = 32'(cur_col);
                     pbi_in         = 2'd0;
                     col_in         = col_inc;
                  end else begin
                     res_data.kind = bsp_pkg::KIND_PAD;
                     out_col32     = 32'(cur_pad);
                     pad_in        = pad_inc;
                  end
                  if (row_end) begin
                     col_in = '0;
                     pad_in = '0;
                     if (last_row) begin
                        res_data.image_done = 1'b1;
                     end else begin
                        row_in = row_inc[DIMENSION_BITS-1:0];
                     end
                  end
               end
            end
            default: res_valid = 1'b0;
         endcase
      end
      res_data.image_width  = out_w32[16:0];
      res_data.image_height = out_h32[16:0];
      res_data.column       = out_col32[16:0];
      res_data.row          = out_row32[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= bsp_pkg::PH_HEADER;
         pos_ff         <= '0;
         magic_ok_ff    <= 1'b0;
         width_word_ff  <= '0;
         height_word_ff <= '0;
         depth_word_ff  <= '0;
         pbi_ff         <= '0;
         held_blue_ff   <= '0;
         held_green_ff  <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         pad_ff         <= '0;
         img_w_ff       <= '0;
         img_h_ff       <= '0;
      end else begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         magic_ok_ff    <= magic_ok_in;
         width_word_ff  <= width_word_in;
         height_word_ff <= height_word_in;
         depth_word_ff  <= depth_word_in;
         pbi_ff         <= pbi_in;
         held_blue_ff   <= held_blue_in;
         held_green_ff  <= held_green_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         pad_ff         <= pad_in;
         img_w_ff       <= img_w_in;
         img_h_ff       <= img_h_in;
      end
   end

   a_done_ends_image: assert property (@(posedge clock) disable iff (reset)
      (step && res_valid && res_data.image_done) |=> (phase_ff == bsp_pkg::PH_DONE))
      else $error("image_done result did not move the parser to done");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bsp_pkg::PH_PIXELS) |-> (col_ff <= img_w_ff))
      else $error("column count ran past the image width");

   a_byte_index_range: assert property (@(posedge clock) disable iff (reset)
      pbi_ff != 2'd3)
      else $error("pixel byte index out of range");

   a_header_position_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bsp_pkg::PH_HEADER) |-> (pos_ff <= bsp_pkg::POS_HEADER_LAST))
      else $error("header position ran past the header");

endmodule

// ----- rtl/bsp_rsp_stage.sv -----
// result register that can load a new result while its waiting result is being taken
module bsp_rsp_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bsp_pkg::rsp_type load_data,
   output logic             out_free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsp_pkg::rsp_type rsp_data
);

   logic             valid_ff, valid_in;
   bsp_pkg::rsp_type data_ff, data_in;

   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

// ----- tb/sv/bmp24_stream_parser_top_tb.sv -----
// testbench for the 24-bit bmp stream parser: file case table, then random files and bytes vs predictor
module bmp24_stream_parser_top_tb;

   localparam int unsigned DIM_CAP = (1 << bsp_pkg::DIMENSION_BITS_DEFAULT) - 1;
   localparam int unsigned HEADER_BYTES = bsp_pkg::POS_HEADER_LAST + 1;
   localparam int unsigned RANDOM_ITEMS = 900;

   typedef struct packed {
      logic [16:0]       max_dim;
      logic [7:0]        magic0;
      logic [7:0]        magic1;
      logic [31:0]       width;
      logic [31:0]       height;
      logic [15:0]       depth;
      bit                partial;
      int unsigned       cut;
      bit                eos_end;
      logic [2:0]        trailing;
      bit                typed;
      bsp_pkg::kind_type kind;
   } file_case_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_PATTERN,
      READY_MOSTLY,
      READY_RARELY
   } ready_mode_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   bsp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   bsp_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [16:0]      csr_wr_data = '0;

   // predictor state
   logic [16:0]         max_dim = bsp_pkg::MAX_DIMENSION_RESET;
   bsp_pkg::phase_type  parse_phase = bsp_pkg::PH_HEADER;
   logic [5:0]          hdr_pos = '0;
   bit                  magic_b_seen = 1'b0;
   logic [31:0]         width_acc = '0;
   logic [31:0]         height_acc = '0;
   logic [15:0]         depth_acc = '0;
   int unsigned         rgb_slot = 0;
   logic [7:0]          blue_hold = '0;
   logic [7:0]          green_hold = '0;
   int unsigned         col_cnt = 0;
   int unsigned         row_cnt = 0;
   int unsigned         pad_idx = 0;
   logic [31:0]         acc_width = '0;
   logic [31:0]         acc_height = '0;

   bsp_pkg::rsp_type pending_results[$];
   bsp_pkg::rsp_type want;
   bit               typed_pending = 1'b0;
   bsp_pkg::rsp_type typed_rsp = '0;
   file_case_type    dir_cases[$];
   int unsigned      fails = 0;
   int unsigned      items_sent = 0;
   int unsigned      burst_left = 0;

   int             hold_ticket = 0;
   int             hold_seen = 0;
   int unsigned    hold_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   logic [31:0]    ready_pat = '1;
   int unsigned    ready_span = 0;

   bmp24_stream_parser_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic bit dim_fits(input logic [31:0] word, input int unsigned limit);
      return !word[31] && (word != 32'd0) && (word <= limit);
   endfunction

   // advances the predictor by one request; returns 1 when the request yields a result
   function automatic bit decode_byte(input bsp_pkg::req_type r, output bsp_pkg::rsp_type res);
      int unsigned pos;
      int unsigned limit;
      int unsigned pad_total;
      bit          row_end;
      res = '0;
      if (r.restart) begin
         parse_phase = bsp_pkg::PH_HEADER;
         hdr_pos = '0;
         magic_b_seen = 1'b0;
         width_acc = '0;
         height_acc = '0;
         depth_acc = '0;
         rgb_slot = 0;
         blue_hold = '0;
         green_hold = '0;
         col_cnt = 0;
         row_cnt = 0;
         pad_idx = 0;
         acc_width = '0;
         acc_height = '0;
      end
      case (parse_phase)
         bsp_pkg::PH_HEADER: begin
            if (r.end_of_stream) begin
               parse_phase = bsp_pkg::PH_STOPPED;
               res.kind = bsp_pkg::KIND_FORMAT;
               return 1'b1;
            end
            pos = 32'(hdr_pos);
            if (pos == bsp_pkg::POS_MAGIC_FIRST) begin
               magic_b_seen = (r.data_byte == bsp_pkg::MAGIC_FIRST);
            end else if (pos == bsp_pkg::POS_MAGIC_SECOND) begin
               if (!magic_b_seen || r.data_byte != bsp_pkg::MAGIC_SECOND) begin
                  parse_phase = bsp_pkg::PH_STOPPED;
                  res.kind = bsp_pkg::KIND_FORMAT;
                  return 1'b1;
               end
            end else if (pos >= bsp_pkg::POS_WIDTH_LO && pos <= bsp_pkg::POS_WIDTH_HI) begin
               width_acc[8 * (pos - bsp_pkg::POS_WIDTH_LO) +: 8] = r.data_byte;
            end else if (pos >= bsp_pkg::POS_HEIGHT_LO && pos <= bsp_pkg::POS_HEIGHT_HI) begin
               height_acc[8 * (pos - bsp_pkg::POS_HEIGHT_LO) +: 8] = r.data_byte;
            end else if (pos >= bsp_pkg::POS_DEPTH_LO && pos <= bsp_pkg::POS_DEPTH_HI) begin
               depth_acc[8 * (pos - bsp_pkg::POS_DEPTH_LO) +: 8] = r.data_byte;
            end
            if (pos == bsp_pkg::POS_HEADER_LAST) begin
               limit = (32'(max_dim) < DIM_CAP) ? 32'(max_dim) : DIM_CAP;
               if (dim_fits(width_acc, limit) && dim_fits(height_acc, limit) &&
                   depth_acc == bsp_pkg::DEPTH_24) begin
                  acc_width = width_acc;
                  acc_height = height_acc;
                  parse_phase = bsp_pkg::PH_PIXELS;
                  res.kind = bsp_pkg::KIND_HEADER_OK;
                  res.image_width = acc_width[16:0];
                  res.image_height = acc_height[16:0];
               end else begin
                  parse_phase = bsp_pkg::PH_STOPPED;
                  res.kind = bsp_pkg::KIND_FORMAT;
               end
               return 1'b1;
            end
            hdr_pos = hdr_pos + 6'd1;
            return 1'b0;
         end
         bsp_pkg::PH_PIXELS: begin
            res.image_width = acc_width[16:0];
            res.image_height = acc_height[16:0];
            if (r.end_of_stream) begin
               parse_phase = bsp_pkg::PH_STOPPED;
               res.kind = bsp_pkg::KIND_PREMATURE;
               res.column = col_cnt[16:0];
               res.row = row_cnt[16:0];
               return 1'b1;
            end
            pad_total = acc_width % 4;
            row_end = 1'b0;
            if (col_cnt < acc_width) begin
               // bytes arrive blue, green, red
               if (rgb_slot == 0) begin
                  blue_hold = r.data_byte;
                  rgb_slot = 1;
                  return 1'b0;
               end
               if (rgb_slot == 1) begin
                  green_hold = r.data_byte;
                  rgb_slot = 2;
                  return 1'b0;
               end
               rgb_slot = 0;
               res.kind = bsp_pkg::KIND_PIXEL;
               res.red = r.data_byte;
               res.green = green_hold;
               res.blue = blue_hold;
               res.column = col_cnt[16:0];
               col_cnt++;
               row_end = (col_cnt == acc_width) && (pad_total == 0);
            end else begin
               res.kind = bsp_pkg::KIND_PAD;
               res.column = pad_idx[16:0];
               pad_idx = (pad_idx + 1) % 4;
               row_end = (pad_idx == pad_total);
            end
            res.row = row_cnt[16:0];
            if (row_end) begin
               col_cnt = 0;
               pad_idx = 0;
               if (row_cnt + 1 >= acc_height) begin
                  res.image_done = 1'b1;
                  parse_phase = bsp_pkg::PH_DONE;
               end else begin
                  row_cnt++;
               end
            end
            return 1'b1;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic int unsigned file_len(input file_case_type fc);
      if (fc.width >= 1 && fc.width <= 64 && fc.height >= 1 && fc.height <= 64)
         return HEADER_BYTES + fc.height * (3 * fc.width + fc.width % 4);
      return HEADER_BYTES;
   endfunction

   function automatic file_case_type case_row(input int unsigned cfg, input logic [7:0] m0,
                                              input logic [7:0] m1, input logic [31:0] w,
                                              input logic [31:0] h, input logic [15:0] d,
                                              input int cut, input int eos, input int typed,
                                              input bsp_pkg::kind_type kind);
      file_case_type fc;
      fc = '0;
      fc.max_dim = 17'(cfg);
      fc.magic0 = m0;
      fc.magic1 = m1;
      fc.width = w;
      fc.height = h;
      fc.depth = d;
      fc.partial = (cut >= 0);
      fc.cut = (cut >= 0) ? cut : 0;
      fc.eos_end = (eos != 0);
      fc.typed = (typed != 0);
      fc.kind = kind;
      return fc;
   endfunction

   function automatic logic [31:0] odd_dim();
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return 32'h8000_0000 | $urandom;
         2: return 32'(max_dim) + 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed small images, some with a broken header or a cut stream
   function automatic file_case_type random_file();
      file_case_type fc;
      int unsigned   total;
      fc = '0;
      fc.max_dim = max_dim;
      fc.magic0 = bsp_pkg::MAGIC_FIRST;
      fc.magic1 = bsp_pkg::MAGIC_SECOND;
      fc.width = $urandom_range(1, 10);
      fc.height = $urandom_range(1, 4);
      fc.depth = bsp_pkg::DEPTH_24;
      fc.kind = bsp_pkg::KIND_HEADER_OK;
      if (max_dim <= 10 && $urandom_range(0, 2) == 0)
         fc.width = 32'(max_dim);
      case ($urandom_range(0, 19))
         0: fc.magic0 = 8'($urandom);
         1: fc.magic1 = 8'($urandom);
         2: fc.width = odd_dim();
         3: fc.height = odd_dim();
         4: fc.depth = 16'($urandom);
         default: ;
      endcase
      total = file_len(fc);
      if ($urandom_range(0, 5) == 0) begin
         fc.partial = 1'b1;
         fc.cut = $urandom_range(0, total - 1);
         fc.eos_end = ($urandom_range(0, 1) == 1);
      end else begin
         fc.eos_end = ($urandom_range(0, 4) == 0);
      end
      if ($urandom_range(0, 3) == 0)
         fc.trailing = 3'($urandom_range(1, 4));
      return fc;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fails++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp_v);
      if (got !== exp_v)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_v));
   endtask

   // offers one request, waits for it to be taken, then predicts its result
   task automatic push_item(input logic [7:0] b, input bit eos, input bit rst);
      bsp_pkg::req_type r;
      bsp_pkg::rsp_type res;
      int unsigned      gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      r.data_byte = b;
      r.end_of_stream = eos;
      r.restart = rst;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (decode_byte(r, res)) begin
         if (typed_pending) begin
            pending_results.push_back(typed_rsp);
            typed_pending = 1'b0;
         end else begin
            pending_results.push_back(res);
         end
      end
   endtask

   task automatic send_file(input file_case_type fc);
      int unsigned n;
      int unsigned i;
      logic [7:0]  b;
      n = fc.partial ? fc.cut : file_len(fc);
      typed_pending = fc.typed;
      typed_rsp = '0;
      typed_rsp.kind = fc.kind;
      if (fc.kind == bsp_pkg::KIND_HEADER_OK) begin
         typed_rsp.image_width = fc.width[16:0];
         typed_rsp.image_height = fc.height[16:0];
      end
      for (i = 0; i < n; i++) begin
         b = 8'($urandom);
         if (i == bsp_pkg::POS_MAGIC_FIRST)
            b = fc.magic0;
         else if (i == bsp_pkg::POS_MAGIC_SECOND)
            b = fc.magic1;
         else if (i >= bsp_pkg::POS_WIDTH_LO && i <= bsp_pkg::POS_WIDTH_HI)
            b = fc.width[8 * (i - bsp_pkg::POS_WIDTH_LO) +: 8];
         else if (i >= bsp_pkg::POS_HEIGHT_LO && i <= bsp_pkg::POS_HEIGHT_HI)
            b = fc.height[8 * (i - bsp_pkg::POS_HEIGHT_LO) +: 8];
         else if (i >= bsp_pkg::POS_DEPTH_LO && i <= bsp_pkg::POS_DEPTH_HI)
            b = fc.depth[8 * (i - bsp_pkg::POS_DEPTH_LO) +: 8];
         push_item(b, 1'b0, i == 0);
      end
      // an empty file puts restart on the end-of-stream request itself
      if (fc.eos_end)
         push_item(8'($urandom), 1'b1, n == 0);
      repeat (fc.trailing) push_item(8'($urandom), 1'b0, 1'b0);
      typed_pending = 1'b0;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic set_max_dim(input logic [16:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_dim = value;
   endtask

   // receiver: changing stall patterns, plus a long hold when the sender asks for one
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = 300;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (ready_span == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            ready_pat = $urandom;
            ready_span = $urandom_range(20, 200);
         end
         ready_span--;
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_PATTERN: begin
               rsp_ready <= ready_pat[0];
               ready_pat = {ready_pat[0], ready_pat[31:1]};
            end
            READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no request waiting for one");
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 32'(rsp_data.kind), 32'(want.kind));
            check_field("red", 32'(rsp_data.red), 32'(want.red));
            check_field("green", 32'(rsp_data.green), 32'(want.green));
            check_field("blue", 32'(rsp_data.blue), 32'(want.blue));
            check_field("image_width", 32'(rsp_data.image_width), 32'(want.image_width));
            check_field("image_height", 32'(rsp_data.image_height), 32'(want.image_height));
            check_field("column", 32'(rsp_data.column), 32'(want.column));
            check_field("row", 32'(rsp_data.row), 32'(want.row));
            check_field("image_done", 32'(rsp_data.image_done), 32'(want.image_done));
         end
      end
   end

   initial begin
      int unsigned target;
      int unsigned phase_no;
      // image sizes cover all four padding lengths
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 2, 2,
                                   bsp_pkg::DEPTH_24, -1, 0, 1, bsp_pkg::KIND_HEADER_OK));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 1, 1,
                                   bsp_pkg::DEPTH_24, -1, 0, 1, bsp_pkg::KIND_HEADER_OK));
      // end of stream after the image is ignored
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 3, 2,
                                   bsp_pkg::DEPTH_24, -1, 1, 1, bsp_pkg::KIND_HEADER_OK));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 4, 1,
                                   bsp_pkg::DEPTH_24, -1, 0, 1, bsp_pkg::KIND_HEADER_OK));
      // bad magic, first then second byte
      dir_cases.push_back(case_row(100000, 8'h58, bsp_pkg::MAGIC_SECOND, 2, 2,
                                   bsp_pkg::DEPTH_24, 8, 0, 1, bsp_pkg::KIND_FORMAT));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, 8'h4E, 2, 2,
                                   bsp_pkg::DEPTH_24, 8, 0, 1, bsp_pkg::KIND_FORMAT));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 0, 2,
                                   bsp_pkg::DEPTH_24, 54, 0, 1, bsp_pkg::KIND_FORMAT));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND,
                                   32'h8000_0001, 2, bsp_pkg::DEPTH_24, 54, 0, 1,
                                   bsp_pkg::KIND_FORMAT));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 2,
                                   32'hFFFF_FFFF, bsp_pkg::DEPTH_24, 54, 0, 1,
                                   bsp_pkg::KIND_FORMAT));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 2, 2,
                                   16'd32, 54, 0, 1, bsp_pkg::KIND_FORMAT));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 2, 2,
                                   16'h0118, 54, 0, 1, bsp_pkg::KIND_FORMAT));
      // stream ends inside the header, then an empty file
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 2, 2,
                                   bsp_pkg::DEPTH_24, 30, 1, 1, bsp_pkg::KIND_FORMAT));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 2, 2,
                                   bsp_pkg::DEPTH_24, 0, 1, 1, bsp_pkg::KIND_FORMAT));
      // premature end, then an image abandoned by a restart
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 3, 2,
                                   bsp_pkg::DEPTH_24, 59, 1, 1, bsp_pkg::KIND_HEADER_OK));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 2, 3,
                                   bsp_pkg::DEPTH_24, 60, 0, 1, bsp_pkg::KIND_HEADER_OK));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND,
                                   100000, 1, bsp_pkg::DEPTH_24, 58, 1, 1,
                                   bsp_pkg::KIND_HEADER_OK));
      dir_cases.push_back(case_row(100000, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND,
                                   100001, 1, bsp_pkg::DEPTH_24, 54, 0, 1,
                                   bsp_pkg::KIND_FORMAT));
      dir_cases.push_back(case_row(1, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 1, 1,
                                   bsp_pkg::DEPTH_24, -1, 0, 1, bsp_pkg::KIND_HEADER_OK));
      dir_cases.push_back(case_row(1, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 2, 1,
                                   bsp_pkg::DEPTH_24, 54, 0, 1, bsp_pkg::KIND_FORMAT));
      dir_cases.push_back(case_row(1, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND, 1, 2,
                                   bsp_pkg::DEPTH_24, 54, 0, 1, bsp_pkg::KIND_FORMAT));
      dir_cases.push_back(case_row(131071, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND,
                                   131071, 131071, bsp_pkg::DEPTH_24, 61, 1, 1,
                                   bsp_pkg::KIND_HEADER_OK));
      dir_cases.push_back(case_row(131071, bsp_pkg::MAGIC_FIRST, bsp_pkg::MAGIC_SECOND,
                                   131072, 1, bsp_pkg::DEPTH_24, 54, 0, 1,
                                   bsp_pkg::KIND_FORMAT));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_cases[k]) begin
         if (dir_cases[k].max_dim != max_dim) begin
            drain_results();
            set_max_dim(dir_cases[k].max_dim);
         end
         send_file(dir_cases[k]);
      end

      target = items_sent + RANDOM_ITEMS;
      phase_no = 0;
      while (items_sent < target) begin
         drain_results();
         case ($urandom_range(0, 4))
            0: set_max_dim(17'd1);
            1: set_max_dim(17'd131071);
            2: set_max_dim(bsp_pkg::MAX_DIMENSION_RESET);
            3: set_max_dim(17'($urandom_range(1, 12)));
            default: set_max_dim(17'($urandom_range(1, 131071)));
         endcase
         // long receiver hold while requests keep coming
         if (phase_no == 0 || phase_no == 3)
            hold_ticket <= hold_ticket + 1;
         repeat ($urandom_range(4, 8)) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(5, 20))
                  push_item(8'($urandom), $urandom_range(0, 7) == 0,
                            $urandom_range(0, 7) == 0);
            end else begin
               send_file(random_file());
            end
         end
         phase_no++;
      end

      drain_results();
      if (fails == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
